// File: design/pulse_dial_line_controller_defines.svh
// Assertion macros used by the line controller top level.
`ifndef PULSE_DIAL_LINE_CONTROLLER_DEFINES_SVH
`define PULSE_DIAL_LINE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PDLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdlc assertion failed");

// Next-cycle implication, checked out of reset.
`define PDLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdlc assertion failed");

`endif

// File: design/pdlc_pkg.sv
`timescale 1ns / 1ps
package pdlc_pkg;

  localparam int NUM_TIMERS  = 5;
  localparam int DELAY_W     = 14;
  localparam int DIGIT_W     = 3;
  localparam int PULSE_W     = 4;
  localparam int CFG_INDEX_W = 3;

  localparam int TM_DIALSTART  = 0;
  localparam int TM_HANGUP     = 1;
  localparam int TM_PICKUP     = 2;
  localparam int TM_BREAK      = 3;
  localparam int TM_INTERDIGIT = 4;

  localparam logic [PULSE_W-1:0] PULSE_SAT = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIAL_START   = 3'd0,
    REG_PICKUP       = 3'd1,
    REG_HANGUP       = 3'd2,
    REG_BREAK        = 3'd3,
    REG_INTERDIGIT   = 3'd4,
    REG_DIGITS       = 3'd5,
    REG_MAX_PULSES   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_OFFHOOK = 3'd1,
    ST_BUSY    = 3'd2,
    ST_DIAL    = 3'd3,
    ST_CALL    = 3'd4
  } line_state_t;

  typedef enum logic [1:0] {
    TONE_NONE     = 2'd0,
    TONE_READY    = 2'd1,
    TONE_ENGAGED  = 2'd2,
    TONE_RINGBACK = 2'd3
  } tone_t;

  typedef struct packed {
    logic [DELAY_W-1:0] dial_start_timeout;
    logic [DELAY_W-1:0] pickup_delay;
    logic [DELAY_W-1:0] hangup_delay;
    logic [DELAY_W-1:0] break_delay;
    logic [DELAY_W-1:0] interdigit_delay;
    logic [DIGIT_W-1:0] digits_per_number;
    logic [PULSE_W-1:0] max_pulses;
  } cfg_t;

  typedef struct packed {
    logic [NUM_TIMERS-1:0] start;
    logic [NUM_TIMERS-1:0] stop;
  } timer_cmd_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digits_collected;
    logic [PULSE_W-1:0] digit_pulses;
    logic               digit_valid;
    line_state_t        call_state;
    tone_t              tone_select;
  } result_t;

  function automatic tone_t tone_of(line_state_t s);
    tone_t t;
    case (s)
      ST_OFFHOOK: t = TONE_READY;
      ST_BUSY:    t = TONE_ENGAGED;
      ST_CALL:    t = TONE_RINGBACK;
      default:    t = TONE_NONE;
    endcase
    return t;
  endfunction

endpackage

// File: design/pdlc_cfg.sv
`timescale 1ns / 1ps
module pdlc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pdlc_pkg::DELAY_W-1:0]        cfg_data,
  output pdlc_pkg::cfg_t                      cfg
);

  pdlc_pkg::cfg_t cfg_r;
  pdlc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (pdlc_pkg::cfg_reg_t'(cfg_index))
        pdlc_pkg::REG_DIAL_START: cfg_nxt.dial_start_timeout = cfg_data;
        pdlc_pkg::REG_PICKUP:     cfg_nxt.pickup_delay       = cfg_data;
        pdlc_pkg::REG_HANGUP:     cfg_nxt.hangup_delay       = cfg_data;
        pdlc_pkg::REG_BREAK:      cfg_nxt.break_delay        = cfg_data;
        pdlc_pkg::REG_INTERDIGIT: cfg_nxt.interdigit_delay   = cfg_data;
        pdlc_pkg::REG_DIGITS:
          cfg_nxt.digits_per_number = cfg_data[pdlc_pkg::DIGIT_W-1:0];
        pdlc_pkg::REG_MAX_PULSES:
          cfg_nxt.max_pulses = cfg_data[pdlc_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dial_start_timeout <= 14'd8000;
      cfg_r.pickup_delay       <= 14'd200;
      cfg_r.hangup_delay       <= 14'd200;
      cfg_r.break_delay        <= 14'd30;
      cfg_r.interdigit_delay   <= 14'd100;
      cfg_r.digits_per_number  <= 3'd4;
      cfg_r.max_pulses         <= 4'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/pdlc_timers.sv
`timescale 1ns / 1ps
module pdlc_timers #(
  parameter int TIMER_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  pdlc_pkg::cfg_t                      cfg,
  input  pdlc_pkg::timer_cmd_t                cmd,
  output logic [pdlc_pkg::NUM_TIMERS-1:0]     expired
);

  localparam int WIDE_W = TIMER_BITS + pdlc_pkg::DELAY_W;

  logic [TIMER_BITS-1:0] count_r   [pdlc_pkg::NUM_TIMERS];
  logic [TIMER_BITS-1:0] count_nxt [pdlc_pkg::NUM_TIMERS];
  logic [TIMER_BITS-1:0] load_val  [pdlc_pkg::NUM_TIMERS];

  function automatic logic [TIMER_BITS-1:0] fit(logic [pdlc_pkg::DELAY_W-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = {{TIMER_BITS{1'b0}}, v};
    return wide[TIMER_BITS-1:0];
  endfunction

  always_comb begin
    load_val[pdlc_pkg::TM_DIALSTART]  = fit(cfg.dial_start_timeout);
    load_val[pdlc_pkg::TM_HANGUP]     = fit(cfg.hangup_delay);
    load_val[pdlc_pkg::TM_PICKUP]     = fit(cfg.pickup_delay);
    load_val[pdlc_pkg::TM_BREAK]      = fit(cfg.break_delay);
    load_val[pdlc_pkg::TM_INTERDIGIT] = fit(cfg.interdigit_delay);
  end

  // A timer at zero is stopped; one at one fires on this tick.
  always_comb begin
    for (int i = 0; i < pdlc_pkg::NUM_TIMERS; i++) begin
      expired[i] = (count_r[i] == TIMER_BITS'(1));
      count_nxt[i] = (count_r[i] != '0) ? count_r[i] - TIMER_BITS'(1) : '0;
      if (cmd.start[i]) count_nxt[i] = load_val[i];
      if (cmd.stop[i])  count_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pdlc_pkg::NUM_TIMERS; i++) count_r[i] <= '0;
    end else if (advance) begin
      for (int i = 0; i < pdlc_pkg::NUM_TIMERS; i++) count_r[i] <= count_nxt[i];
    end
  end

endmodule

// File: design/pdlc_core.sv
`timescale 1ns / 1ps
module pdlc_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                advance,
  input  logic                                loop_open,
  input  pdlc_pkg::cfg_t                      cfg,
  input  logic [pdlc_pkg::NUM_TIMERS-1:0]     expired,
  output pdlc_pkg::timer_cmd_t                cmd,
  output pdlc_pkg::result_t                   result
);

  pdlc_pkg::line_state_t          state_r, state_nxt;
  logic [pdlc_pkg::PULSE_W-1:0]   pulse_r, pulse_nxt;
  logic [pdlc_pkg::DIGIT_W-1:0]   digit_r, digit_nxt;
  logic                           last_open_r;
  logic                           opened;
  logic                           closed;
  logic                           dv;
  logic [pdlc_pkg::PULSE_W-1:0]   dp;

  assign opened = loop_open && !last_open_r;
  assign closed = !loop_open && last_open_r;

  // Timer events in fixed order, then the loop edge.
  always_comb begin
    state_nxt = state_r;
    pulse_nxt = pulse_r;
    digit_nxt = digit_r;
    dv        = 1'b0;
    dp        = '0;
    cmd       = '0;

    if (expired[pdlc_pkg::TM_DIALSTART]) state_nxt = pdlc_pkg::ST_BUSY;
    if (expired[pdlc_pkg::TM_HANGUP])    state_nxt = pdlc_pkg::ST_IDLE;
    if (expired[pdlc_pkg::TM_PICKUP]) begin
      state_nxt = pdlc_pkg::ST_OFFHOOK;
      pulse_nxt = '0;
      digit_nxt = '0;
      cmd.start[pdlc_pkg::TM_DIALSTART] = 1'b1;
    end
    if (expired[pdlc_pkg::TM_BREAK] && state_nxt == pdlc_pkg::ST_DIAL) begin
      if (pulse_nxt != pdlc_pkg::PULSE_SAT) pulse_nxt = pulse_nxt + 1'b1;
      if (pulse_nxt > cfg.max_pulses) state_nxt = pdlc_pkg::ST_BUSY;
    end
    if (expired[pdlc_pkg::TM_INTERDIGIT] && state_nxt == pdlc_pkg::ST_DIAL) begin
      dv        = 1'b1;
      dp        = pulse_nxt;
      digit_nxt = digit_nxt + 1'b1;
      pulse_nxt = '0;
      if (digit_nxt == cfg.digits_per_number) state_nxt = pdlc_pkg::ST_CALL;
    end

    if (opened) begin
      cmd.start[pdlc_pkg::TM_HANGUP]    = 1'b1;
      cmd.start[pdlc_pkg::TM_BREAK]     = 1'b1;
      cmd.stop[pdlc_pkg::TM_INTERDIGIT] = 1'b1;
      if (state_nxt == pdlc_pkg::ST_IDLE) begin
        cmd.stop[pdlc_pkg::TM_PICKUP] = 1'b1;
      end else if (state_nxt == pdlc_pkg::ST_OFFHOOK) begin
        state_nxt = pdlc_pkg::ST_DIAL;
        cmd.stop[pdlc_pkg::TM_DIALSTART] = 1'b1;
      end
    end
    if (closed) begin
      cmd.stop[pdlc_pkg::TM_HANGUP] = 1'b1;
      if (state_nxt == pdlc_pkg::ST_IDLE) begin
        cmd.start[pdlc_pkg::TM_PICKUP] = 1'b1;
      end else if (state_nxt == pdlc_pkg::ST_DIAL) begin
        cmd.stop[pdlc_pkg::TM_BREAK]       = 1'b1;
        cmd.start[pdlc_pkg::TM_INTERDIGIT] = 1'b1;
      end
    end

    result.tone_select      = pdlc_pkg::tone_of(state_nxt);
    result.call_state       = state_nxt;
    result.digit_valid      = dv;
    result.digit_pulses     = dp;
    result.digits_collected = digit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pdlc_pkg::ST_IDLE;
      pulse_r     <= '0;
      digit_r     <= '0;
      last_open_r <= 1'b1;
    end else if (advance) begin
      state_r     <= state_nxt;
      pulse_r     <= pulse_nxt;
      digit_r     <= digit_nxt;
      last_open_r <= loop_open;
    end
  end

endmodule

// File: design/pulse_dial_line_controller.sv
`timescale 1ns / 1ps
// A result item is captured in the output register when its input item is accepted.
// Throughput: one item per cycle while out_tready is not held low; the line state,
// counters and five timers are updated in a single pass each accepted item, the output register holds a stall.
// Reset (rst_n, synchronous, active low): line idle, timers stopped, counts zero,
// loop taken as open, registers back to their defaults, output empty.
`include "pulse_dial_line_controller_defines.svh"
module pulse_dial_line_controller #(
  parameter int TIMER_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] loop_open, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [1:0] tone_select, [4:2] call_state, [5] digit_valid,
                                   // [9:6] digit_pulses, [12:10] digits_collected, [15:13] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  pdlc_pkg::cfg_t                     cfg;
  pdlc_pkg::timer_cmd_t               cmd;
  pdlc_pkg::result_t                  result;
  logic [pdlc_pkg::NUM_TIMERS-1:0]    expired;
  logic                               advance;

  pdlc_pkg::result_t                  out_data_r;
  logic                               out_valid_r, out_valid_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign advance   = in_tvalid && in_tready;

  pdlc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdlc_timers #(.TIMER_BITS(TIMER_BITS)) u_timers (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .cmd     (cmd),
    .expired (expired)
  );

  pdlc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .loop_open (in_tdata[0]),
    .cfg       (cfg),
    .expired   (expired),
    .cmd       (cmd),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)         out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r};

  `PDLC_ASSERT_NEXT(a_accept_fills_out, clk, rst_n, advance, out_tvalid)
  `PDLC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))
  `PDLC_ASSERT_NOW(a_digit_in_dial, clk, rst_n, out_valid_r && out_data_r.digit_valid,
                   out_data_r.call_state == pdlc_pkg::ST_DIAL ||
                   out_data_r.call_state == pdlc_pkg::ST_CALL)

endmodule

// File: test/line_report_checker.sv
`timescale 1ns / 1ps
module line_report_checker
  import pdlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  // line model
  line_state_t        line_st;
  logic [DELAY_W-1:0] tmr [NUM_TIMERS];
  logic [PULSE_W-1:0] pulses;
  logic [DIGIT_W-1:0] digits;
  logic               last_open;
  logic               finished;
  logic [PULSE_W-1:0] finished_pulses;

  // register copies
  logic [DELAY_W-1:0] dial_to;
  logic [DELAY_W-1:0] pickup_d;
  logic [DELAY_W-1:0] hangup_d;
  logic [DELAY_W-1:0] break_d;
  logic [DELAY_W-1:0] gap_d;
  logic [DIGIT_W-1:0] digits_goal;
  logic [PULSE_W-1:0] pulse_limit;

  result_t tick_reports_q[$];
  int      seen;

  task automatic complain(input string what);
    $display("%0t line checker: %s", $time, what);
    mismatches++;
  endtask

  function automatic void move_to(line_state_t s);
    if (s == ST_OFFHOOK) begin
      tmr[TM_DIALSTART] = dial_to;
      pulses = '0;
      digits = '0;
    end else if (s == ST_DIAL) begin
      tmr[TM_DIALSTART] = '0;
    end
    line_st = s;
  endfunction

  function automatic void expire(int which);
    case (which)
      TM_DIALSTART: move_to(ST_BUSY);
      TM_HANGUP:    move_to(ST_IDLE);
      TM_PICKUP:    move_to(ST_OFFHOOK);
      TM_BREAK: begin
        if (line_st == ST_DIAL) begin
          if (pulses != PULSE_SAT) pulses = pulses + 1'b1;
          if (pulses > pulse_limit) move_to(ST_BUSY);
        end
      end
      TM_INTERDIGIT: begin
        if (line_st == ST_DIAL) begin
          finished = 1'b1;
          finished_pulses = pulses;
          digits = digits + 1'b1;
          pulses = '0;
          if (digits == digits_goal) move_to(ST_CALL);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic result_t line_tick(logic open);
    result_t r;
    int i;
    finished = 1'b0;
    finished_pulses = '0;
    // timers run in fixed order, an expiry may rearm an earlier one this tick
    for (i = 0; i < NUM_TIMERS; i++) begin
      if (tmr[i] != '0) begin
        tmr[i] = tmr[i] - 1'b1;
        if (tmr[i] == '0) expire(i);
      end
    end
    if (open != last_open) begin
      last_open = open;
      if (open) begin
        tmr[TM_HANGUP] = hangup_d;
        tmr[TM_BREAK] = break_d;
        tmr[TM_INTERDIGIT] = '0;
        if (line_st == ST_IDLE) tmr[TM_PICKUP] = '0;
        else if (line_st == ST_OFFHOOK) move_to(ST_DIAL);
      end else begin
        tmr[TM_HANGUP] = '0;
        if (line_st == ST_IDLE) begin
          tmr[TM_PICKUP] = pickup_d;
        end else if (line_st == ST_DIAL) begin
          tmr[TM_BREAK] = '0;
          tmr[TM_INTERDIGIT] = gap_d;
        end
      end
    end
    case (line_st)
      ST_OFFHOOK: r.tone_select = TONE_READY;
      ST_BUSY:    r.tone_select = TONE_ENGAGED;
      ST_CALL:    r.tone_select = TONE_RINGBACK;
      default:    r.tone_select = TONE_NONE;
    endcase
    r.call_state = line_st;
    r.digit_valid = finished;
    r.digit_pulses = finished_pulses;
    r.digits_collected = digits;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      line_st = ST_IDLE;
      foreach (tmr[k]) tmr[k] = '0;
      pulses = '0;
      digits = '0;
      last_open = 1'b1;
      dial_to = 14'd8000;
      pickup_d = 14'd200;
      hangup_d = 14'd200;
      break_d = 14'd30;
      gap_d = 14'd100;
      digits_goal = 3'd4;
      pulse_limit = 4'd10;
      tick_reports_q.delete();
      seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIAL_START: dial_to = cfg_data;
          REG_PICKUP:     pickup_d = cfg_data;
          REG_HANGUP:     hangup_d = cfg_data;
          REG_BREAK:      break_d = cfg_data;
          REG_INTERDIGIT: gap_d = cfg_data;
          REG_DIGITS:     digits_goal = cfg_data[DIGIT_W-1:0];
          REG_MAX_PULSES: pulse_limit = cfg_data[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) tick_reports_q.push_back(line_tick(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        if (tick_reports_q.size() == 0) begin
          complain($sformatf("result item %0d arrived with none expected", seen));
        end else begin
          want = tick_reports_q.pop_front();
          got = result_t'(out_tdata[12:0]);
          if (got.tone_select !== want.tone_select)
            complain($sformatf("item %0d tone_select %0d, expected %0d",
                               seen, got.tone_select, want.tone_select));
          if (got.call_state !== want.call_state)
            complain($sformatf("item %0d call_state %0d, expected %0d",
                               seen, got.call_state, want.call_state));
          if (got.digit_valid !== want.digit_valid)
            complain($sformatf("item %0d digit_valid %0d, expected %0d",
                               seen, got.digit_valid, want.digit_valid));
          if (got.digit_pulses !== want.digit_pulses)
            complain($sformatf("item %0d digit_pulses %0d, expected %0d",
                               seen, got.digit_pulses, want.digit_pulses));
          if (got.digits_collected !== want.digits_collected)
            complain($sformatf("item %0d digits_collected %0d, expected %0d",
                               seen, got.digits_collected, want.digits_collected));
          if (out_tdata[15:13] !== 3'd0)
            complain($sformatf("item %0d padding bits %b", seen, out_tdata[15:13]));
        end
        seen++;
      end
    end
    outstanding = tick_reports_q.size();
  end

endmodule

// File: test/tb_pulse_dial_line_controller.sv
`timescale 1ns / 1ps
module tb_pulse_dial_line_controller;
  import pdlc_pkg::*;

  localparam int          TOTAL_TICKS = 1925;
  localparam int          CALM_FROM   = TOTAL_TICKS - 200;
  localparam int          SLOW_DELAY  = 64;
  localparam logic [2:0]  CFG_SPARE   = 3'd7;
  localparam int          PH_DIRECTED = 0;
  localparam int          PH_HIGHS    = 3;
  localparam int          PH_ZERO_A   = 4;
  localparam int          PH_ZERO_B   = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [13:0] cfg_data = 14'd0;

  int mismatches;
  int outstanding;
  int sent = 0;
  bit calm = 1'b0;
  bit squeezed = 1'b0;
  int setting [7];

  pulse_dial_line_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_report_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, one long hold-off to back up the input
  initial begin : sink
    int  hold_off;
    logic rdy;
    hold_off = 0;
    forever begin
      @(negedge clk);
      if (!squeezed && sent >= 300) begin
        squeezed = 1'b1;
        hold_off = 60;
      end
      if (hold_off > 0) begin
        rdy = 1'b0;
        hold_off--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rdy = 1'b0;
        hold_off = $urandom_range(0, 17);
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  task automatic send_tick(input logic open);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, open};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
    calm = (sent >= CALM_FROM);
  endtask

  task automatic hold(input logic open, input int ticks);
    repeat (ticks) send_tick(open);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic configure(input int ph);
    int raw [7];
    int i;
    case (ph)
      PH_DIRECTED: raw = '{3, 1, 3, 1, 2, 1, 2};
      1:           raw = '{40, 3, 6, 2, 5, 4, 10};
      2:           raw = '{1, 1, 1, 1, 1, 7, 14};
      PH_HIGHS:    raw = '{16383, 16383, 16383, 16383, 16383, 16383, 16383};
      PH_ZERO_A:   raw = '{0, 2, 0, 3, 4, 8, 15};
      PH_ZERO_B:   raw = '{5, 0, 4, 0, 0, 3, 0};
      6:           raw = '{25, 4, 8, 3, 6, 0, 15};
      default: begin
        raw = '{$urandom_range(4, 60), $urandom_range(1, 8), $urandom_range(1, 12),
                $urandom_range(1, 5), $urandom_range(1, 10), $urandom_range(0, 15),
                $urandom_range(0, 31)};
      end
    endcase
    for (i = 0; i < 7; i++) begin
      write_reg(i[2:0], raw[i][13:0]);
      setting[i] = raw[i] & 16383;
    end
    setting[REG_DIGITS] = raw[REG_DIGITS] & 7;
    setting[REG_MAX_PULSES] = raw[REG_MAX_PULSES] & 15;
    // unused index, must change nothing
    write_reg(CFG_SPARE, $urandom_range(0, 16383));
    cfg_valid <= 1'b0;
  endtask

  task automatic noise_run();
    repeat ($urandom_range(4, 12)) hold($urandom_range(0, 1), $urandom_range(1, 6));
  endtask

  task automatic place_call();
    int pu, hd, bk, gp, ds, dl, mx;
    int kind, n, k, d, p;
    ds = setting[REG_DIAL_START];
    pu = setting[REG_PICKUP];
    hd = setting[REG_HANGUP];
    bk = setting[REG_BREAK];
    gp = setting[REG_INTERDIGIT];
    dl = setting[REG_DIGITS];
    mx = setting[REG_MAX_PULSES];
    kind = $urandom_range(0, 9);
    hold(1'b1, hd + $urandom_range(0, 3));
    if (kind == 0) begin
      noise_run();
      return;
    end
    hold(1'b0, pu + $urandom_range(0, 2));
    // off hook but never dials
    if (kind == 1) begin
      hold(1'b0, ds + $urandom_range(1, 3));
      return;
    end
    n = (dl == 0) ? 8 : dl;
    if (kind == 2) n = $urandom_range(1, n);
    for (d = 0; d < n; d++) begin
      if (kind == 3 && d == n - 1) k = mx + $urandom_range(1, 3);
      else k = $urandom_range(1, (mx == 0) ? 1 : mx);
      for (p = 0; p < k; p++) begin
        hold(1'b1, bk + $urandom_range(0, 1));
        if (p < k - 1) hold(1'b0, (gp > 1) ? $urandom_range(1, gp - 1) : 1);
      end
      hold(1'b0, gp + $urandom_range(0, 2));
    end
    hold(1'b0, $urandom_range(1, 8));
  endtask

  initial begin : stimulus
    logic [24:0] opening;
    int ph, i, stop_at;
    bit slow;
    opening = 25'b0_1010_1010_0000_1111_1000_1001;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    configure(PH_DIRECTED);
    for (i = 0; i < 25; i++) send_tick(opening[i]);
    ph = 1;
    while (sent < TOTAL_TICKS) begin
      drain();
      configure(ph);
      slow = 1'b0;
      for (i = 0; i < 5; i++) if (setting[i] > SLOW_DELAY) slow = 1'b1;
      if (ph == PH_HIGHS) stop_at = sent + 60;
      else if (ph == PH_ZERO_A || ph == PH_ZERO_B) stop_at = sent + 90;
      else stop_at = sent + 220;
      while (sent < stop_at) begin
        if (slow) noise_run();
        else place_call();
      end
      ph++;
    end
    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
